[src/teq_pkg.sv]
package teq_pkg;

  // Fixed widths of the stream fields
  localparam int TIME_FIELD_W = 48;
  localparam int SLOT_FIELD_W = 4;
  localparam int IN_TDATA_W   = 144;
  localparam int OUT_TDATA_W  = 56;

  // Most expiries reported by one tick
  localparam int MAX_RESULTS = 16;

  // Defaults for the top-level parameters
  localparam int DEF_TIMER_SLOTS = 16;
  localparam int DEF_TIME_BITS   = 48;

  // Operation codes carried on in_tuser
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds carried on out_tuser
  localparam logic [1:0] KIND_ADDED   = 2'd0;
  localparam logic [1:0] KIND_FULL    = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]              kind;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    next_valid;
    logic                    last;
  } res_t;

endpackage

[src/teq_ram.sv]
module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[src/teq_front.sv]
module teq_front #(
  parameter int TIME_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [teq_pkg::TIME_FIELD_W-1:0]  in_expiry,
  input  logic [teq_pkg::TIME_FIELD_W-1:0]  in_interval,
  input  logic [teq_pkg::TIME_FIELD_W-1:0]  in_current,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output logic                              cmd_op,
  output logic [TIME_BITS-1:0]              cmd_time,
  output logic [TIME_BITS-1:0]              cmd_ival
);
  import teq_pkg::*;

  localparam int WIDE_W = (TIME_BITS > TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W;
  localparam int ENT_W  = 1 + 2 * TIME_BITS;

  logic [WIDE_W-1:0]    exp_wide, ival_wide, cur_wide;
  logic [TIME_BITS-1:0] sel_time, sel_ival;
  logic [ENT_W-1:0]     fifo_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 push, pop;

  assign exp_wide  = WIDE_W'(in_expiry);
  assign ival_wide = WIDE_W'(in_interval);
  assign cur_wide  = WIDE_W'(in_current);

  // Classify: a tick carries only its time, an add its expiry and interval
  always_comb begin
    if (in_op == OP_TICK) begin
      sel_time = cur_wide[TIME_BITS-1:0];
      sel_ival = '0;
    end else begin
      sel_time = exp_wide[TIME_BITS-1:0];
      sel_ival = ival_wide[TIME_BITS-1:0];
    end
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign {cmd_op, cmd_time, cmd_ival} = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= {in_op, sel_time, sel_ival};
    end
  end

endmodule

[src/teq_back.sv]
module teq_back #(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  logic                             cmd_op,
  input  logic [TIME_BITS-1:0]             cmd_time,
  input  logic [TIME_BITS-1:0]             cmd_ival,
  output logic                             out_valid,
  input  logic                             out_ready,
  output teq_pkg::res_t                    out_res,
  output logic [teq_pkg::TIME_FIELD_W-1:0] out_next
);
  import teq_pkg::*;

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int LIST_N = (TIMER_SLOTS < MAX_RESULTS) ? TIMER_SLOTS : MAX_RESULTS;
  localparam int LIDX_W = (LIST_N > 1) ? $clog2(LIST_N) : 1;
  localparam int LCNT_W = $clog2(LIST_N + 1);
  localparam int SW4    = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
  localparam int WIDE_W = (TIME_BITS > TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]             st_r, st_nxt;
  logic [TIMER_SLOTS-1:0] busy_r, busy_nxt;
  logic [TIME_BITS-1:0]   min_r, min_nxt;
  logic                   minv_r, minv_nxt;
  logic [TIME_BITS-1:0]   now_r, now_nxt;
  logic [SLOT_W-1:0]      scan_addr_r, scan_addr_nxt;
  logic                   scan_iss_r, scan_iss_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0]      rd_slot_r, rd_slot_nxt;
  logic [TIME_BITS-1:0]   lst_exp_r [LIST_N];
  logic [TIME_BITS-1:0]   lst_exp_nxt [LIST_N];
  logic [SLOT_W-1:0]      lst_slot_r [LIST_N];
  logic [SLOT_W-1:0]      lst_slot_nxt [LIST_N];
  logic [LIST_N-1:0]      lst_vld_r, lst_vld_nxt;
  logic [LCNT_W-1:0]      idx_r, idx_nxt;
  logic                   upd_vld_r, upd_vld_nxt;
  logic [SLOT_W-1:0]      upd_slot_r, upd_slot_nxt;
  logic                   out_vld_r, out_vld_nxt;
  res_t                   out_res_r, out_res_nxt;
  logic [TIME_FIELD_W-1:0] out_next_r, out_next_nxt;

  logic [TIME_BITS-1:0]   exp_rdata, ival_rdata;
  logic                   exp_we, ival_we;
  logic [SLOT_W-1:0]      exp_waddr;
  logic [TIME_BITS-1:0]   exp_wdata;
  logic [SLOT_W-1:0]      free_slot;
  logic                   free_ok;
  logic [LIST_N-1:0]      gt;
  logic [TIME_BITS-1:0]   ins_exp [LIST_N];
  logic [SLOT_W-1:0]      ins_slot [LIST_N];
  logic [LIST_N-1:0]      ins_vld;
  logic [TIME_BITS-1:0]   drop_val;
  logic [LIST_N:0]        lst_more;
  logic [LIDX_W-1:0]      lidx;
  logic [LCNT_W-1:0]      idx_inc;
  logic [TIME_BITS:0]     rearm_sum;
  logic [TIME_BITS-1:0]   rearm;
  logic                   out_free;
  logic                   fold_en;
  logic [TIME_BITS-1:0]   fold_val;
  logic                   push;
  logic [1:0]             push_kind;
  logic [SLOT_W-1:0]      push_slot;
  logic                   push_last;
  logic [SW4-1:0]         slot_wide;
  logic [WIDE_W-1:0]      next_wide;

  teq_ram #(.WIDTH(TIME_BITS), .DEPTH(TIMER_SLOTS)) u_exp_ram (
    .clk     (clk),
    .wr_en   (exp_we),
    .wr_addr (exp_waddr),
    .wr_data (exp_wdata),
    .rd_addr (scan_addr_r),
    .rd_data (exp_rdata)
  );

  teq_ram #(.WIDTH(TIME_BITS), .DEPTH(TIMER_SLOTS)) u_ival_ram (
    .clk     (clk),
    .wr_en   (ival_we),
    .wr_addr (free_slot),
    .wr_data (cmd_ival),
    .rd_addr (lst_slot_r[lidx]),
    .rd_data (ival_rdata)
  );

  assign lst_more = {1'b0, lst_vld_r};
  assign lidx     = idx_r[LIDX_W-1:0];
  assign idx_inc  = idx_r + 1'b1;
  assign out_free = !out_vld_r || out_ready;

  // Lowest free slot
  always_comb begin
    free_slot = '0;
    free_ok   = 1'b0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_slot = SLOT_W'(i);
        free_ok   = 1'b1;
      end
    end
  end

  // Sorted insertion: equal expiries stay ahead since slots arrive in order
  always_comb begin
    for (int j = 0; j < LIST_N; j++) begin
      gt[j] = !lst_vld_r[j] || (lst_exp_r[j] > exp_rdata);
    end
  end

  always_comb begin
    for (int j = 0; j < LIST_N; j++) begin
      ins_exp[j]  = lst_exp_r[j];
      ins_slot[j] = lst_slot_r[j];
      ins_vld[j]  = lst_vld_r[j];
      if (gt[j]) begin
        ins_exp[j]  = exp_rdata;
        ins_slot[j] = rd_slot_r;
        ins_vld[j]  = 1'b1;
        if (j > 0) begin
          if (gt[j-1]) begin
            ins_exp[j]  = lst_exp_r[j-1];
            ins_slot[j] = lst_slot_r[j-1];
            ins_vld[j]  = lst_vld_r[j-1];
          end
        end
      end
    end
    drop_val = gt[LIST_N-1] ? lst_exp_r[LIST_N-1] : exp_rdata;
  end

  // Re-arm time, saturated at the top of the time range
  always_comb begin
    rearm_sum = {1'b0, now_r} + {1'b0, ival_rdata};
    rearm     = rearm_sum[TIME_BITS] ? TIME_MAX : rearm_sum[TIME_BITS-1:0];
  end

  always_comb begin
    st_nxt        = st_r;
    busy_nxt      = busy_r;
    min_nxt       = min_r;
    minv_nxt      = minv_r;
    now_nxt       = now_r;
    scan_addr_nxt = scan_addr_r;
    scan_iss_nxt  = scan_iss_r;
    rd_vld_nxt    = 1'b0;
    rd_slot_nxt   = rd_slot_r;
    lst_exp_nxt   = lst_exp_r;
    lst_slot_nxt  = lst_slot_r;
    lst_vld_nxt   = lst_vld_r;
    idx_nxt       = idx_r;
    upd_vld_nxt   = 1'b0;
    upd_slot_nxt  = upd_slot_r;
    exp_we        = 1'b0;
    exp_waddr     = free_slot;
    exp_wdata     = cmd_time;
    ival_we       = 1'b0;
    fold_en       = 1'b0;
    fold_val      = cmd_time;
    push          = 1'b0;
    push_kind     = KIND_NONE;
    push_slot     = '0;
    push_last     = 1'b1;
    cmd_ready     = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        cmd_ready = (cmd_op == OP_TICK) || out_free;
        if (cmd_valid && cmd_ready) begin
          if (cmd_op == OP_ADD) begin
            push = 1'b1;
            if (free_ok) begin
              busy_nxt[free_slot] = 1'b1;
              exp_we    = 1'b1;
              ival_we   = 1'b1;
              fold_en   = 1'b1;
              push_kind = KIND_ADDED;
              push_slot = free_slot;
            end else begin
              push_kind = KIND_FULL;
            end
          end else begin
            now_nxt       = cmd_time;
            min_nxt       = '0;
            minv_nxt      = 1'b0;
            lst_vld_nxt   = '0;
            scan_addr_nxt = '0;
            scan_iss_nxt  = 1'b1;
            st_nxt        = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_iss_r) begin
          rd_vld_nxt  = 1'b1;
          rd_slot_nxt = scan_addr_r;
          if (scan_addr_r == SLOT_W'(TIMER_SLOTS - 1)) begin
            scan_iss_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + 1'b1;
          end
        end
        if (rd_vld_r && busy_r[rd_slot_r]) begin
          if (exp_rdata <= now_r) begin
            lst_exp_nxt  = ins_exp;
            lst_slot_nxt = ins_slot;
            lst_vld_nxt  = ins_vld;
            // A full list drops the largest of its entries and the new one; it stays pending
            if (lst_vld_r[LIST_N-1]) begin
              fold_en  = 1'b1;
              fold_val = drop_val;
            end
          end else begin
            fold_en  = 1'b1;
            fold_val = exp_rdata;
          end
        end
        if (!scan_iss_r && !rd_vld_r) begin
          st_nxt  = ST_UPDATE;
          idx_nxt = '0;
        end
      end
      ST_UPDATE: begin
        if (lst_more[idx_r]) begin
          upd_vld_nxt  = 1'b1;
          upd_slot_nxt = lst_slot_r[lidx];
          idx_nxt      = idx_inc;
        end
        if (upd_vld_r) begin
          if (ival_rdata != '0) begin
            exp_we    = 1'b1;
            exp_waddr = upd_slot_r;
            exp_wdata = rearm;
            fold_en   = 1'b1;
            fold_val  = rearm;
          end else begin
            busy_nxt[upd_slot_r] = 1'b0;
          end
        end
        if (!lst_more[idx_r] && !upd_vld_r) begin
          st_nxt  = ST_EMIT;
          idx_nxt = '0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          push = 1'b1;
          if (!lst_more[0]) begin
            push_kind = KIND_NONE;
            st_nxt    = ST_IDLE;
          end else begin
            push_kind = KIND_EXPIRED;
            push_slot = lst_slot_r[lidx];
            push_last = !lst_more[idx_inc];
            if (push_last) begin
              st_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_inc;
            end
          end
        end
      end
    endcase

    if (fold_en && (!minv_nxt || (fold_val < min_nxt))) begin
      min_nxt  = fold_val;
      minv_nxt = 1'b1;
    end

    slot_wide    = SW4'(push_slot);
    next_wide    = WIDE_W'(min_nxt);
    out_vld_nxt  = out_vld_r && !out_ready;
    out_res_nxt  = out_res_r;
    out_next_nxt = out_next_r;
    if (push) begin
      out_vld_nxt            = 1'b1;
      out_res_nxt.kind       = push_kind;
      out_res_nxt.slot       = slot_wide[SLOT_FIELD_W-1:0];
      out_res_nxt.next_valid = minv_nxt;
      out_res_nxt.last       = push_last;
      out_next_nxt           = next_wide[TIME_FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      busy_r     <= '0;
      min_r      <= '0;
      minv_r     <= 1'b0;
      scan_iss_r <= 1'b0;
      rd_vld_r   <= 1'b0;
      lst_vld_r  <= '0;
      idx_r      <= '0;
      upd_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      busy_r     <= busy_nxt;
      min_r      <= min_nxt;
      minv_r     <= minv_nxt;
      scan_iss_r <= scan_iss_nxt;
      rd_vld_r   <= rd_vld_nxt;
      lst_vld_r  <= lst_vld_nxt;
      idx_r      <= idx_nxt;
      upd_vld_r  <= upd_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    scan_addr_r <= scan_addr_nxt;
    rd_slot_r   <= rd_slot_nxt;
    lst_exp_r   <= lst_exp_nxt;
    lst_slot_r  <= lst_slot_nxt;
    upd_slot_r  <= upd_slot_nxt;
    out_res_r   <= out_res_nxt;
    out_next_r  <= out_next_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;
  assign out_next  = out_next_r;

`ifndef SYNTH
  a_list_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (lst_vld_r & (lst_vld_r + 1'b1)) == '0)
    else $error("expiry list has a hole");

  a_min_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !minv_r |-> (min_r == '0))
    else $error("earliest expiry not cleared while nothing pending");

  a_min_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> (minv_r == (|busy_r)))
    else $error("earliest expiry valid disagrees with busy slots");

  a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && cmd_valid && cmd_ready && cmd_op == OP_ADD) |=> out_vld_r)
    else $error("add produced no result");
`endif

endmodule

[src/timer_expiry_queue_unit.sv]
// Timer queue with periodic re-arm.
// Input stream (in_*): in_tuser selects the transaction, 0 adds a timer (expiry and
// interval in in_tdata), 1 is a tick carrying the current time.
// Output stream (out_*): one result per add; one result per expired timer on a
// tick, up to MAX_RESULTS (the rest stay pending), in ascending expiry order
// (ties to the lower slot), or a single "nothing expired" result. out_tlast marks
// the final result of a transaction and every result carries the earliest pending
// expiry after that transaction. Flow: an add passes through the two-entry input
// queue and the output register before its result is offered on out_tvalid. A tick
// runs a scan, a re-arm pass and an emit pass, emitting one result per cycle while
// out_tready is high; the scan reads the expiry RAM through its single read port,
// one slot per cycle, and the re-arm pass reads one interval a cycle.
// Throughput: one add per cycle while out_tready is high; a tick holds the engine
// through all of its passes.
// Reset: every slot is free and nothing is pending; no clearing pass is needed.
// Stall: a result waits in the output register while out_tready is low; adds and
// emission hold, a tick still scans, and a two-entry queue takes input until full.
module timer_expiry_queue_unit #(
  parameter int TIMER_SLOTS = teq_pkg::DEF_TIMER_SLOTS,
  parameter int TIME_BITS   = teq_pkg::DEF_TIME_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // expiry_time [47:0], repeat_interval [95:48], current_time [143:96]
  input  logic [teq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation [0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // slot [3:0], next_expiry [51:4], next_valid [52], zero pad [55:53]
  output logic [teq_pkg::OUT_TDATA_W-1:0] out_tdata,
  // kind [1:0]
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast
);
  import teq_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - SLOT_FIELD_W - TIME_FIELD_W - 1;

  logic                    cmd_valid, cmd_ready, cmd_op;
  logic [TIME_BITS-1:0]    cmd_time, cmd_ival;
  res_t                    res;
  logic [TIME_FIELD_W-1:0] res_next;

  // Front: take transactions, pick the time fields, queue them
  teq_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser),
    .in_expiry   (in_tdata[TIME_FIELD_W-1:0]),
    .in_interval (in_tdata[2*TIME_FIELD_W-1:TIME_FIELD_W]),
    .in_current  (in_tdata[3*TIME_FIELD_W-1:2*TIME_FIELD_W]),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd_op      (cmd_op),
    .cmd_time    (cmd_time),
    .cmd_ival    (cmd_ival)
  );

  // Back: slot store, expiry scan, re-arm and result emission
  teq_back #(.TIMER_SLOTS(TIMER_SLOTS), .TIME_BITS(TIME_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_op    (cmd_op),
    .cmd_time  (cmd_time),
    .cmd_ival  (cmd_ival),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_next  (res_next)
  );

  // Pack the result fields, lowest field first
  assign out_tdata = {{PAD_W{1'b0}}, res.next_valid, res_next, res.slot};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
